// File: hdl/skt_pkg.sv
// Shared types and constants for the sorted key table.
// Used by the controller, the top level and the checker; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package skt_pkg;

  localparam int KEY_W   = 37;
  localparam int HASH_W  = 256;
  localparam int ENTRY_W = KEY_W + HASH_W;
  localparam int CNT_OUT_W = 9;

  localparam logic OP_LOOKUP = 1'b0;
  localparam logic OP_UPSERT = 1'b1;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_MISS = 2'd1;
  localparam logic [1:0] ST_FULL = 2'd2;

  typedef struct packed {
    logic        operation;
    logic [5:0]  level;
    logic [30:0] node_idx;
    logic [63:0] hash_in_w0;
    logic [63:0] hash_in_w1;
    logic [63:0] hash_in_w2;
    logic [63:0] hash_in_w3;
  } skt_in_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [63:0] hash_out_w0;
    logic [63:0] hash_out_w1;
    logic [63:0] hash_out_w2;
    logic [63:0] hash_out_w3;
    logic [8:0]  entry_count;
  } skt_out_t;

  typedef struct packed {
    logic [KEY_W-1:0]  key;
    logic [HASH_W-1:0] hash;
  } skt_entry_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SRCH,
    S_CMP,
    S_CHK,
    S_SHIFT,
    S_SHEND,
    S_INS,
    S_OUT
  } skt_state_t;

endpackage

`default_nettype wire

// File: hdl/skt_ram.sv
// Generic single-write, single-read synchronous RAM with registered read.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module skt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

// File: hdl/skt_ctrl.sv
// Sequencer for the sorted table: binary search, hit check, shift-up and insert.
// Uses skt_pkg; drives the ports of one skt_ram holding key and hash per entry.
`timescale 1ns / 1ps
`default_nettype none

module skt_ctrl #(
  parameter int CAPACITY = 256
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire skt_pkg::skt_in_t              in_data,
  output logic                               res_valid,
  input  wire logic                          res_ready,
  output skt_pkg::skt_out_t                  res_data,
  output logic                               mem_we,
  output logic [$clog2(CAPACITY)-1:0]        mem_waddr,
  output logic [skt_pkg::ENTRY_W-1:0]        mem_wdata,
  output logic [$clog2(CAPACITY)-1:0]        mem_raddr,
  input  wire logic [skt_pkg::ENTRY_W-1:0]   mem_rdata
);

  import skt_pkg::*;

  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);
  localparam logic [CW-1:0] CAP_CNT = CW'(CAPACITY);

  skt_state_t        state_r, state_nxt;
  logic              op_r, op_nxt;
  logic [KEY_W-1:0]  key_r, key_nxt;
  logic [HASH_W-1:0] hash_r, hash_nxt;
  logic [CW-1:0]     lo_r, lo_nxt;
  logic [CW-1:0]     hi_r, hi_nxt;
  logic [CW-1:0]     cnt_r, cnt_nxt;
  logic [AW-1:0]     src_r, src_nxt;
  logic              pend_r, pend_nxt;
  logic [AW-1:0]     pend_addr_r, pend_addr_nxt;
  logic [1:0]        res_status_r, res_status_nxt;
  logic [HASH_W-1:0] res_hash_r, res_hash_nxt;

  skt_entry_t        rd;
  skt_entry_t        new_entry;
  logic [CW-1:0]     mid;
  logic [CW-1:0]     cnt_m1;
  logic              hit;
  logic [CW+CNT_OUT_W-1:0] cnt_ext;

  assign rd        = skt_entry_t'(mem_rdata);
  assign new_entry = '{key: key_r, hash: hash_r};
  assign mid       = lo_r + ((hi_r - lo_r) >> 1);
  assign cnt_m1    = cnt_r - CW'(1);
  assign hit       = (lo_r < cnt_r) && (rd.key == key_r);
  assign cnt_ext   = {{CNT_OUT_W{1'b0}}, cnt_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
      pend_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      pend_r  <= pend_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r         <= op_nxt;
    key_r        <= key_nxt;
    hash_r       <= hash_nxt;
    lo_r         <= lo_nxt;
    hi_r         <= hi_nxt;
    src_r        <= src_nxt;
    pend_addr_r  <= pend_addr_nxt;
    res_status_r <= res_status_nxt;
    res_hash_r   <= res_hash_nxt;
  end

  always_comb begin
    state_nxt      = state_r;
    op_nxt         = op_r;
    key_nxt        = key_r;
    hash_nxt       = hash_r;
    lo_nxt         = lo_r;
    hi_nxt         = hi_r;
    cnt_nxt        = cnt_r;
    src_nxt        = src_r;
    pend_nxt       = 1'b0;
    pend_addr_nxt  = pend_addr_r;
    res_status_nxt = res_status_r;
    res_hash_nxt   = res_hash_r;
    res_valid      = 1'b0;

    // Pending shift write lands in the cycle after its read.
    mem_we    = pend_r;
    mem_waddr = pend_addr_r;
    mem_wdata = mem_rdata;
    mem_raddr = mid[AW-1:0];

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          op_nxt    = in_data.operation;
          key_nxt   = {in_data.level, in_data.node_idx};
          hash_nxt  = {in_data.hash_in_w3, in_data.hash_in_w2,
                       in_data.hash_in_w1, in_data.hash_in_w0};
          lo_nxt    = '0;
          hi_nxt    = cnt_r;
          state_nxt = S_SRCH;
        end
      end
      S_SRCH: begin
        if (lo_r < hi_r) begin
          mem_raddr = mid[AW-1:0];
          state_nxt = S_CMP;
        end else begin
          // Lower bound found; fetch it to test for a hit.
          mem_raddr = lo_r[AW-1:0];
          state_nxt = S_CHK;
        end
      end
      S_CMP: begin
        if (rd.key < key_r) begin
          lo_nxt = mid + CW'(1);
        end else begin
          hi_nxt = mid;
        end
        state_nxt = S_SRCH;
      end
      S_CHK: begin
        res_hash_nxt = '0;
        res_status_nxt = ST_OK;
        if (op_r == OP_LOOKUP) begin
          if (hit) begin
            res_hash_nxt = rd.hash;
          end else begin
            res_status_nxt = ST_MISS;
          end
          state_nxt = S_OUT;
        end else if (hit) begin
          mem_we    = 1'b1;
          mem_waddr = lo_r[AW-1:0];
          mem_wdata = new_entry;
          state_nxt = S_OUT;
        end else if (cnt_r == CAP_CNT) begin
          res_status_nxt = ST_FULL;
          state_nxt      = S_OUT;
        end else if (cnt_r == lo_r) begin
          state_nxt = S_INS;
        end else begin
          src_nxt   = cnt_m1[AW-1:0];
          state_nxt = S_SHIFT;
        end
      end
      S_SHIFT: begin
        // Read src now, write it to src+1 next cycle; walk downward.
        mem_raddr     = src_r;
        pend_nxt      = 1'b1;
        pend_addr_nxt = src_r + AW'(1);
        if (src_r == lo_r[AW-1:0]) begin
          state_nxt = S_SHEND;
        end else begin
          src_nxt = src_r - AW'(1);
        end
      end
      S_SHEND: begin
        state_nxt = S_INS;
      end
      S_INS: begin
        mem_we         = 1'b1;
        mem_waddr      = lo_r[AW-1:0];
        mem_wdata      = new_entry;
        cnt_nxt        = cnt_r + CW'(1);
        res_status_nxt = ST_OK;
        state_nxt      = S_OUT;
      end
      S_OUT: begin
        res_valid = 1'b1;
        if (res_ready) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign in_stall = (state_r != S_IDLE);

  assign res_data = '{
    status:      res_status_r,
    hash_out_w0: res_hash_r[63:0],
    hash_out_w1: res_hash_r[127:64],
    hash_out_w2: res_hash_r[191:128],
    hash_out_w3: res_hash_r[255:192],
    entry_count: cnt_ext[CNT_OUT_W-1:0]
  };

endmodule

`default_nettype wire

// File: hdl/sorted_key_table_upsert_lookup.sv
// Top level of the sorted key table: entry RAM, sequencer and output register.
// Uses skt_pkg, skt_ram and skt_ctrl.
//
//   channel | dir | handshake           | payload
//   in      | in  | in_valid / in_stall | skt_pkg::skt_in_t  in_data
//   out     | out | out_valid/out_stall | skt_pkg::skt_out_t out_data
//
// One item at a time: the block takes it, runs a binary search over the n stored
// entries with one entry RAM read per probe, fetches the lower bound to test for a
// hit, and hands the result to the output register. An insert writes the new entry
// at the lower bound, first moving every entry above it up one slot (one RAM read
// and write per moved entry) when it does not land at the end of the table.
// Reset empties the table by clearing the entry count; there is no clearing pass.
// The next item is taken while a result waits under out_stall.
`timescale 1ns / 1ps
`default_nettype none

module sorted_key_table_upsert_lookup #(
  parameter int CAPACITY = 256
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire skt_pkg::skt_in_t  in_data,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output skt_pkg::skt_out_t      out_data
);

  import skt_pkg::*;

  localparam int AW = $clog2(CAPACITY);

  logic              mem_we;
  logic [AW-1:0]     mem_waddr;
  logic [ENTRY_W-1:0] mem_wdata;
  logic [AW-1:0]     mem_raddr;
  logic [ENTRY_W-1:0] mem_rdata;

  logic              res_valid;
  logic              res_ready;
  skt_out_t          res_data;

  logic              out_valid_r, out_valid_nxt;
  skt_out_t          out_data_r;

  skt_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (CAPACITY)
  ) u_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  skt_ctrl #(
    .CAPACITY (CAPACITY)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res_data  (res_data),
    .mem_we    (mem_we),
    .mem_waddr (mem_waddr),
    .mem_wdata (mem_wdata),
    .mem_raddr (mem_raddr),
    .mem_rdata (mem_rdata)
  );

  assign res_ready = !out_valid_r || !out_stall;

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (res_valid && res_ready) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  // Load a new transaction only when the register is free or draining.
  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      out_data_r <= res_data;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

`default_nettype wire

// File: hdl/skt_checker.sv
// Port-level checks for the sorted key table, bound to the top level.
// Uses skt_pkg; attaches to sorted_key_table_upsert_lookup.
`timescale 1ns / 1ps
`default_nettype none

module skt_checker #(
  parameter int CAPACITY = 256
) (
  input wire logic              clk,
  input wire logic              rst_n,
  input wire logic              in_valid,
  input wire logic              in_stall,
  input wire logic              out_valid,
  input wire logic              out_stall,
  input wire skt_pkg::skt_out_t out_data
);

  import skt_pkg::*;

  localparam logic [CNT_OUT_W-1:0] CAP_OUT = CNT_OUT_W'(CAPACITY);

  // A stalled result stays offered.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("result dropped while stalled");

  // One transaction in flight: the block is busy right after an accept.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("input taken twice in a row");

  // Misses and refused inserts carry no hash.
  a_zero_hash: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.status != ST_OK) |->
      (out_data.hash_out_w0 == '0) && (out_data.hash_out_w1 == '0) &&
      (out_data.hash_out_w2 == '0) && (out_data.hash_out_w3 == '0))
    else $error("nonzero hash on failed transaction");

  // A full refusal reports a full table.
  a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.status == ST_FULL) |-> out_data.entry_count == CAP_OUT)
    else $error("full status with wrong entry count");

endmodule

bind sorted_key_table_upsert_lookup skt_checker #(
  .CAPACITY (CAPACITY)
) u_skt_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

`default_nettype wire
